/* rtl/rrpt_pkg.sv */
// shared types and constants for the russian roulette path terminator
// no dependencies; used by rrpt_div_stage and the top level
package rrpt_pkg;

  localparam int LANES      = 4;
  localparam int LANE_W     = 32;
  localparam int PROB_W     = 17;
  localparam int ETA_W      = 24;
  localparam int DEPTH_W    = 16;
  localparam int SAMPLE_W   = 16;
  localparam int PROD_W     = LANE_W + ETA_W;
  localparam int FRAC_W     = 16;
  localparam int ADDR_W     = 4;
  localparam int DATA_W     = 32;
  localparam int DIV_STAGES = 4;
  localparam int DIV_STEPS  = LANE_W / DIV_STAGES;

  localparam logic [PROB_W-1:0] PROB_ONE = PROB_W'(1) << FRAC_W;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_POLICY = 3'd1,
    ST_BAD_ETA    = 3'd2,
    ST_ZERO_TP    = 3'd3,
    ST_OVERFLOW   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    OC_NOT_EVAL   = 2'd0,
    OC_TERMINATED = 2'd1,
    OC_SURVIVED   = 2'd2
  } outcome_t;

  typedef enum logic [1:0] {
    REG_ENABLED = 2'd0,
    REG_FIRST   = 2'd1,
    REG_MIN     = 2'd2,
    REG_MAX     = 2'd3
  } reg_idx_t;

  typedef logic [LANE_W-1:0] lane_t;
  typedef logic [PROB_W-1:0] prob_t;

  // one item inside the divider pipe
  typedef struct packed {
    status_t                status;
    outcome_t               outcome;
    prob_t                  prob;
    logic                   do_div;
    lane_t [LANES-1:0]      lane;
    prob_t [LANES-1:0]      rem;
    lane_t [LANES-1:0]      acc;
  } div_t;

endpackage

/* rtl/rrpt_div_stage.sv */
// one register stage of the restoring divider, STEPS quotient bits per lane
// depends on rrpt_pkg
module rrpt_div_stage #(
  parameter int STEPS = rrpt_pkg::DIV_STEPS
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_v,
  input  rrpt_pkg::div_t in_d,
  output logic          out_v,
  output rrpt_pkg::div_t out_d
);

  logic           v_r;
  rrpt_pkg::div_t d_r;
  rrpt_pkg::div_t work;

  always_comb begin
    logic [rrpt_pkg::PROB_W:0] t;
    logic                      qbit;
    work = in_d;
    for (int s = 0; s < STEPS; s++) begin
      for (int l = 0; l < rrpt_pkg::LANES; l++) begin
        t = {work.rem[l], work.acc[l][rrpt_pkg::LANE_W-1]};
        qbit = (t >= {1'b0, work.prob});
        if (qbit) begin
          t = t - {1'b0, work.prob};
        end
        work.rem[l] = t[rrpt_pkg::PROB_W-1:0];
        work.acc[l] = {work.acc[l][rrpt_pkg::LANE_W-2:0], qbit};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= work;
    end
  end

  assign out_v = v_r;
  assign out_d = d_r;

endmodule

/* rtl/russian_roulette_path_terminator_unit.sv */
// russian roulette path terminator: fully registered pipeline ending in a result register
// throughput one transaction per cycle; each stage holds only while the one after it is full
// stages: policy/max lane, 32x24 multiply, clamp/decide, four divider stages, output
// the divider (8 quotient bits per stage per lane) sets the stage count
// rst_n is synchronous active low: clears valid bits and the policy registers
// depends on rrpt_pkg and rrpt_div_stage
module russian_roulette_path_terminator_unit (
  input  logic        clk,
  input  logic        rst_n,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_throughput_lane0,
  input  logic [31:0] in_throughput_lane1,
  input  logic [31:0] in_throughput_lane2,
  input  logic [31:0] in_throughput_lane3,
  input  logic [23:0] in_eta_factor,
  input  logic [15:0] in_bounce_depth,
  input  logic [15:0] in_uniform_sample,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [1:0]  out_outcome,
  output logic [16:0] out_survival_prob,
  output logic [31:0] out_lane0,
  output logic [31:0] out_lane1,
  output logic [31:0] out_lane2,
  output logic [31:0] out_lane3
);

  localparam int LANES = rrpt_pkg::LANES;
  localparam int NDIV  = rrpt_pkg::DIV_STAGES;

  // ---------------- policy registers ----------------
  logic                          enabled_r;
  logic [rrpt_pkg::DEPTH_W-1:0]  first_r;
  rrpt_pkg::prob_t               min_r;
  rrpt_pkg::prob_t               max_r;
  rrpt_pkg::reg_idx_t            reg_idx;
  logic                          cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = rrpt_pkg::reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r <= 1'b0;
      first_r   <= '0;
      min_r     <= '0;
      max_r     <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        rrpt_pkg::REG_ENABLED: enabled_r <= pwdata[0];
        rrpt_pkg::REG_FIRST:   first_r   <= pwdata[rrpt_pkg::DEPTH_W-1:0];
        rrpt_pkg::REG_MIN:     min_r     <= pwdata[rrpt_pkg::PROB_W-1:0];
        rrpt_pkg::REG_MAX:     max_r     <= pwdata[rrpt_pkg::PROB_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      rrpt_pkg::REG_ENABLED: prdata = {31'd0, enabled_r};
      rrpt_pkg::REG_FIRST:   prdata = {16'd0, first_r};
      rrpt_pkg::REG_MIN:     prdata = {15'd0, min_r};
      rrpt_pkg::REG_MAX:     prdata = {15'd0, max_r};
      default:               prdata = '0;
    endcase
  end

  // policy check, static between transactions
  logic policy_ok;
  always_comb begin
    if (!enabled_r) begin
      policy_ok = (first_r == '0) && (min_r == '0) && (max_r == '0);
    end else begin
      policy_ok = (first_r != '0) && (min_r != '0) && (min_r < rrpt_pkg::PROB_ONE) &&
                  (max_r >= min_r) && (max_r <= rrpt_pkg::PROB_ONE);
    end
  end

  // ---------------- stage enables (bubbles collapse) ----------------
  logic            en_s1, en_s2, en_s3, en_out;
  logic [NDIV:0]   en_div;
  logic [NDIV:0]   dv;
  rrpt_pkg::div_t  dd [NDIV+1];

  logic s1_v_r, s2_v_r, out_valid_r;

  assign en_out       = !out_valid_r || !out_stall;
  assign en_div[NDIV] = en_out;
  for (genvar k = 0; k < NDIV; k++) begin : g_en
    assign en_div[k] = !dv[k+1] || en_div[k+1];
  end
  assign en_s3    = !dv[0] || en_div[0];
  assign en_s2    = !s2_v_r || en_s3;
  assign en_s1    = !s1_v_r || en_s2;
  assign in_stall = !en_s1;

  // ---------------- stage 1: status, eligibility, max lane ----------------
  rrpt_pkg::lane_t [LANES-1:0]    in_lane;
  rrpt_pkg::lane_t                in_max;
  rrpt_pkg::status_t              s1_status_r;
  logic                           s1_apply_r;
  rrpt_pkg::lane_t                s1_max_r;
  logic [rrpt_pkg::ETA_W-1:0]     s1_eta_r;
  rrpt_pkg::lane_t [LANES-1:0]    s1_lane_r;
  logic [rrpt_pkg::SAMPLE_W-1:0]  s1_sample_r;

  assign in_lane[0] = in_throughput_lane0;
  assign in_lane[1] = in_throughput_lane1;
  assign in_lane[2] = in_throughput_lane2;
  assign in_lane[3] = in_throughput_lane3;

  always_comb begin
    in_max = '0;
    for (int l = 0; l < LANES; l++) begin
      if (in_lane[l] > in_max) begin
        in_max = in_lane[l];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en_s1) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_s1) begin
      if (!policy_ok) begin
        s1_status_r <= rrpt_pkg::ST_BAD_POLICY;
      end else if (in_eta_factor == '0) begin
        s1_status_r <= rrpt_pkg::ST_BAD_ETA;
      end else begin
        s1_status_r <= rrpt_pkg::ST_OK;
      end
      s1_apply_r  <= enabled_r && (in_bounce_depth >= first_r);
      s1_max_r    <= in_max;
      s1_eta_r    <= in_eta_factor;
      s1_lane_r   <= in_lane;
      s1_sample_r <= in_uniform_sample;
    end
  end

  // ---------------- stage 2: max lane times eta ----------------
  rrpt_pkg::status_t              s2_status_r;
  logic                           s2_apply_r;
  logic                           s2_zero_r;
  logic [rrpt_pkg::PROD_W-1:0]    s2_prod_r;
  rrpt_pkg::lane_t [LANES-1:0]    s2_lane_r;
  logic [rrpt_pkg::SAMPLE_W-1:0]  s2_sample_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en_s2) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_s2) begin
      s2_status_r <= s1_status_r;
      s2_apply_r  <= s1_apply_r;
      s2_zero_r   <= (s1_max_r == '0);
      s2_prod_r   <= rrpt_pkg::PROD_W'(s1_max_r) * rrpt_pkg::PROD_W'(s1_eta_r);
      s2_lane_r   <= s2_lane_nxt_passthru(s1_lane_r);
      s2_sample_r <= s1_sample_r;
    end
  end

  function automatic rrpt_pkg::lane_t [LANES-1:0] s2_lane_nxt_passthru(
    input rrpt_pkg::lane_t [LANES-1:0] l
  );
    return l;
  endfunction

  // ---------------- stage 3: clamp, decide, divider setup ----------------
  localparam int PQ_W = rrpt_pkg::PROD_W - rrpt_pkg::FRAC_W;

  logic [PQ_W-1:0]  p_raw, p_lo, min_x, max_x;
  rrpt_pkg::prob_t  p_cl;
  logic             survive, ovf;
  rrpt_pkg::div_t   s3_nxt;
  logic             s3_v_r;
  rrpt_pkg::div_t   s3_r;

  always_comb begin
    p_raw = s2_prod_r[rrpt_pkg::PROD_W-1:rrpt_pkg::FRAC_W];
    min_x = PQ_W'(min_r);
    max_x = PQ_W'(max_r);
    p_lo  = (p_raw < min_x) ? min_x : p_raw;
    p_cl  = (p_lo > max_x) ? max_r : p_lo[rrpt_pkg::PROB_W-1:0];
    survive = ({1'b0, s2_sample_r} < p_cl);
    // quotient needs more than 32 bits exactly when the lane's integer part reaches p
    ovf = 1'b0;
    for (int l = 0; l < LANES; l++) begin
      if ({1'b0, s2_lane_r[l][rrpt_pkg::LANE_W-1:rrpt_pkg::FRAC_W]} >= p_cl) begin
        ovf = 1'b1;
      end
    end

    s3_nxt.lane   = s2_lane_r;
    s3_nxt.do_div = 1'b0;
    for (int l = 0; l < LANES; l++) begin
      s3_nxt.rem[l] = rrpt_pkg::PROB_W'(s2_lane_r[l][rrpt_pkg::LANE_W-1:rrpt_pkg::FRAC_W]);
      s3_nxt.acc[l] = {s2_lane_r[l][rrpt_pkg::FRAC_W-1:0], {rrpt_pkg::FRAC_W{1'b0}}};
    end

    if (s2_status_r != rrpt_pkg::ST_OK) begin
      s3_nxt.status  = s2_status_r;
      s3_nxt.outcome = rrpt_pkg::OC_NOT_EVAL;
      s3_nxt.prob    = '0;
    end else if (!s2_apply_r) begin
      s3_nxt.status  = rrpt_pkg::ST_OK;
      s3_nxt.outcome = rrpt_pkg::OC_NOT_EVAL;
      s3_nxt.prob    = rrpt_pkg::PROB_ONE;
    end else if (s2_zero_r) begin
      s3_nxt.status  = rrpt_pkg::ST_ZERO_TP;
      s3_nxt.outcome = rrpt_pkg::OC_NOT_EVAL;
      s3_nxt.prob    = '0;
    end else if (!survive) begin
      s3_nxt.status  = rrpt_pkg::ST_OK;
      s3_nxt.outcome = rrpt_pkg::OC_TERMINATED;
      s3_nxt.prob    = p_cl;
    end else if (ovf) begin
      s3_nxt.status  = rrpt_pkg::ST_OVERFLOW;
      s3_nxt.outcome = rrpt_pkg::OC_NOT_EVAL;
      s3_nxt.prob    = '0;
    end else begin
      s3_nxt.status  = rrpt_pkg::ST_OK;
      s3_nxt.outcome = rrpt_pkg::OC_SURVIVED;
      s3_nxt.prob    = p_cl;
      s3_nxt.do_div  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en_s3) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_s3) begin
      s3_r <= s3_nxt;
    end
  end

  // ---------------- divider pipe: 32 quotient bits over NDIV stages ----------------
  assign dv[0] = s3_v_r;
  assign dd[0] = s3_r;

  for (genvar k = 0; k < NDIV; k++) begin : g_div
    rrpt_div_stage #(
      .STEPS(rrpt_pkg::DIV_STEPS)
    ) u_div (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en_div[k]),
      .in_v  (dv[k]),
      .in_d  (dd[k]),
      .out_v (dv[k+1]),
      .out_d (dd[k+1])
    );
  end

  // ---------------- output register ----------------
  rrpt_pkg::div_t               fin;
  rrpt_pkg::status_t            out_status_r;
  rrpt_pkg::outcome_t           out_outcome_r;
  rrpt_pkg::prob_t              out_prob_r;
  rrpt_pkg::lane_t [LANES-1:0]  out_lane_r;
  rrpt_pkg::lane_t [LANES-1:0]  lane_sel;

  assign fin = dd[NDIV];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      if (fin.status != rrpt_pkg::ST_OK) begin
        lane_sel[l] = '0;
      end else if (fin.do_div) begin
        lane_sel[l] = fin.acc[l];
      end else begin
        lane_sel[l] = fin.lane[l];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en_out) begin
      out_valid_r <= dv[NDIV];
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      out_status_r  <= fin.status;
      out_outcome_r <= fin.outcome;
      out_prob_r    <= fin.prob;
      out_lane_r    <= lane_sel;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_outcome       = out_outcome_r;
  assign out_survival_prob = out_prob_r;
  assign out_lane0         = out_lane_r[0];
  assign out_lane1         = out_lane_r[1];
  assign out_lane2         = out_lane_r[2];
  assign out_lane3         = out_lane_r[3];

`ifndef SYNTHESIS
  // error results carry no outcome, probability or lanes
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r != rrpt_pkg::ST_OK) |->
      (out_outcome_r == rrpt_pkg::OC_NOT_EVAL) && (out_prob_r == '0) && (out_lane_r == '0))
    else $error("error result with nonzero payload");

  // unevaluated ok results use probability one
  a_noeval_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r == rrpt_pkg::ST_OK) &&
      (out_outcome_r == rrpt_pkg::OC_NOT_EVAL) |-> (out_prob_r == rrpt_pkg::PROB_ONE))
    else $error("unevaluated result without probability one");

  // a survivor was divided by a nonzero probability
  a_surv_prob: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_outcome_r == rrpt_pkg::OC_SURVIVED) |->
      (out_prob_r != '0) && (out_status_r == rrpt_pkg::ST_OK))
    else $error("survivor with zero probability");

  // a held result stays in place while the receiver stalls
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(out_lane_r) && $stable(out_status_r))
    else $error("result changed under stall");
`endif

endmodule

/* tb/tb_top.sv */
// testbench for russian_roulette_path_terminator_unit: random and directed transactions
// checked against a behavioral predictor; depends on rrpt_pkg and the rtl
module tb_top;

  localparam int LANES = rrpt_pkg::LANES;

  logic        clk;
  logic        rst_n;
  logic        psel, penable, pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] in_throughput_lane0, in_throughput_lane1;
  logic [31:0] in_throughput_lane2, in_throughput_lane3;
  logic [23:0] in_eta_factor;
  logic [15:0] in_bounce_depth;
  logic [15:0] in_uniform_sample;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_status;
  logic [1:0]  out_outcome;
  logic [16:0] out_survival_prob;
  logic [31:0] out_lane0, out_lane1, out_lane2, out_lane3;

  russian_roulette_path_terminator_unit u_top (.*);

  // one path vertex as sent and one verdict as expected
  typedef struct {
    rrpt_pkg::lane_t [LANES-1:0]            lane;
    logic [rrpt_pkg::ETA_W-1:0]    eta;
    logic [rrpt_pkg::DEPTH_W-1:0]  depth;
    logic [rrpt_pkg::SAMPLE_W-1:0] sample;
  } vertex_t;

  typedef struct {
    rrpt_pkg::status_t           status;
    rrpt_pkg::outcome_t          outcome;
    rrpt_pkg::prob_t             prob;
    rrpt_pkg::lane_t [LANES-1:0] lane;
  } verdict_t;

  // predictor copy of the policy registers
  logic                         pol_enabled;
  logic [rrpt_pkg::DEPTH_W-1:0] pol_first;
  rrpt_pkg::prob_t              pol_min;
  rrpt_pkg::prob_t              pol_max;

  verdict_t pending_verdicts[$];
  int       mismatches;
  int       verdicts_seen;
  int       survived_seen, terminated_seen, error_seen;
  bit       hold_off;      // long receiver stall requested by a test
  bit       steady_sink;   // receiver never stalls
  bit       steady_source; // sender never idles

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("timeout");
    $display("FAILED: results differ");
    $finish;
  end

  function automatic bit policy_valid();
    if (!pol_enabled) return pol_first == 0 && pol_min == 0 && pol_max == 0;
    if (pol_first == 0) return 0;
    if (pol_min == 0 || pol_min >= rrpt_pkg::PROB_ONE) return 0;
    if (pol_max < pol_min || pol_max > rrpt_pkg::PROB_ONE) return 0;
    return 1;
  endfunction

  function automatic verdict_t error_verdict(rrpt_pkg::status_t code);
    verdict_t v;
    v.status = code;
    v.outcome = rrpt_pkg::OC_NOT_EVAL;
    v.prob = '0;
    v.lane = '0;
    return v;
  endfunction

  // roulette decision for one vertex
  function automatic verdict_t roulette_verdict(vertex_t x);
    verdict_t    v;
    logic [31:0] maxlane;
    logic [55:0] product;
    logic [39:0] p;
    logic [47:0] quo;
    maxlane = 0;
    if (!policy_valid()) return error_verdict(rrpt_pkg::ST_BAD_POLICY);
    if (x.eta == 0) return error_verdict(rrpt_pkg::ST_BAD_ETA);
    v.status = rrpt_pkg::ST_OK;
    v.lane = x.lane;
    if (!pol_enabled || x.depth < pol_first) begin
      v.outcome = rrpt_pkg::OC_NOT_EVAL;
      v.prob = rrpt_pkg::PROB_ONE;
      return v;
    end
    for (int i = 0; i < LANES; i++)
      if (x.lane[i] > maxlane) maxlane = x.lane[i];
    if (maxlane == 0) return error_verdict(rrpt_pkg::ST_ZERO_TP);
    product = 56'(maxlane) * 56'(x.eta);
    p = 40'(product >> 16);
    if (p < 40'(pol_min)) p = 40'(pol_min);
    if (p > 40'(pol_max)) p = 40'(pol_max);
    v.prob = rrpt_pkg::prob_t'(p);
    if (40'(x.sample) >= p) begin
      v.outcome = rrpt_pkg::OC_TERMINATED;
      return v;
    end
    v.outcome = rrpt_pkg::OC_SURVIVED;
    for (int i = 0; i < LANES; i++) begin
      quo = {x.lane[i], 16'h0} / 48'(p);
      if (quo > 48'hFFFF_FFFF) return error_verdict(rrpt_pkg::ST_OVERFLOW);
      v.lane[i] = quo[31:0];
    end
    return v;
  endfunction

  // short gaps mostly, a long one now and then
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic write_reg(rrpt_pkg::reg_idx_t idx, logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= 4'(idx) << 2; pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      rrpt_pkg::REG_ENABLED: pol_enabled = value[0];
      rrpt_pkg::REG_FIRST:   pol_first = value[rrpt_pkg::DEPTH_W-1:0];
      rrpt_pkg::REG_MIN:     pol_min = value[rrpt_pkg::PROB_W-1:0];
      default:               pol_max = value[rrpt_pkg::PROB_W-1:0];
    endcase
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic set_policy(logic en, logic [15:0] first, rrpt_pkg::prob_t mn,
                            rrpt_pkg::prob_t mx);
    write_reg(rrpt_pkg::REG_ENABLED, 32'(en));
    write_reg(rrpt_pkg::REG_FIRST, 32'(first));
    write_reg(rrpt_pkg::REG_MIN, 32'(mn));
    write_reg(rrpt_pkg::REG_MAX, 32'(mx));
  endtask

  // stop offering, called at a falling edge
  task automatic stop_source();
    in_valid <= 1'b0;
  endtask

  // wait for the pipe to drain before touching registers
  task automatic drain();
    stop_source();
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // offer one transaction, starting at a falling edge, return at the falling edge
  // after it was accepted; valid stays high so the next one can follow at once
  task automatic send_vertex(vertex_t x);
    int gap;
    gap = steady_source ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    {in_throughput_lane3, in_throughput_lane2, in_throughput_lane1,
     in_throughput_lane0} <= x.lane;
    in_eta_factor <= x.eta;
    in_bounce_depth <= x.depth;
    in_uniform_sample <= x.sample;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_verdicts.push_back(roulette_verdict(x));
    @(negedge clk);
  endtask

  function automatic rrpt_pkg::lane_t rand_lane();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(0, 32'h0001_0000);
      3: return $urandom_range(0, 255);
      default: return $urandom;
    endcase
  endfunction

  function automatic vertex_t rand_vertex();
    vertex_t x;
    for (int i = 0; i < LANES; i++) x.lane[i] = rand_lane();
    case ($urandom_range(0, 4))
      0: x.eta = 0;
      1: x.eta = 24'hFF_FFFF;
      2: x.eta = 24'($urandom_range(1, 24'h02_0000));
      default: x.eta = 24'($urandom);
    endcase
    x.depth = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 12));
    x.sample = 16'($urandom);
    return x;
  endfunction

  function automatic vertex_t make_vertex(rrpt_pkg::lane_t l0, rrpt_pkg::lane_t l1,
                                          rrpt_pkg::lane_t l2, rrpt_pkg::lane_t l3,
                                          logic [23:0] eta, logic [15:0] depth,
                                          logic [15:0] sample);
    vertex_t x;
    x.lane = {l3, l2, l1, l0};
    x.eta = eta; x.depth = depth; x.sample = sample;
    return x;
  endfunction

  // receiver: random stalls, optional long hold-off
  initial begin
    int gap;
    out_stall = 1'b1;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (60) @(negedge clk);
        hold_off = 0;
      end
      gap = steady_sink ? 0 : idle_len();
      out_stall <= (gap != 0);
      if (gap > 1) repeat (gap - 1) @(negedge clk);
    end
  end

  // result checker
  always @(posedge clk) begin
    verdict_t e;
    if (rst_n && out_valid && !out_stall) begin
      verdicts_seen++;
      if (pending_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result at %0t", $time);
      end else begin
        e = pending_verdicts.pop_front();
        if (out_outcome == rrpt_pkg::OC_SURVIVED) survived_seen++;
        if (out_outcome == rrpt_pkg::OC_TERMINATED) terminated_seen++;
        if (out_status != rrpt_pkg::ST_OK) error_seen++;
        if (out_status !== e.status || out_outcome !== e.outcome ||
            out_survival_prob !== e.prob || out_lane0 !== e.lane[0] ||
            out_lane1 !== e.lane[1] || out_lane2 !== e.lane[2] ||
            out_lane3 !== e.lane[3]) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch at %0t: exp st=%0d oc=%0d p=%0h l=%h/%h/%h/%h",
                     $time, e.status, e.outcome, e.prob, e.lane[0], e.lane[1],
                     e.lane[2], e.lane[3]);
            $display("  got st=%0d oc=%0d p=%0h l=%h/%h/%h/%h",
                     out_status, out_outcome, out_survival_prob,
                     out_lane0, out_lane1, out_lane2, out_lane3);
          end
        end
      end
    end
  end

  // reset defaults: disabled, all zero
  task automatic test_disabled_passthrough();
    send_vertex(make_vertex(32'hFFFF_FFFF, 0, 32'h1234_5678, 1, 24'hFF_FFFF, 16'hFFFF, 0));
    send_vertex(make_vertex(0, 0, 0, 0, 24'h1, 0, 16'hFFFF));
    send_vertex(make_vertex(5, 6, 7, 8, 0, 3, 9)); // zero eta
    drain();
  endtask

  // each kind of broken policy register set
  task automatic test_bad_policy();
    vertex_t x;
    x = make_vertex(32'h1_0000, 2, 3, 4, 24'h1_0000, 5, 100);
    set_policy(0, 1, 0, 0); send_vertex(x); drain();
    set_policy(1, 0, 100, 200); send_vertex(x); drain();
    set_policy(1, 1, 0, 200); send_vertex(x); drain();
    set_policy(1, 1, 17'h1_0000, 17'h1_0000); send_vertex(x); drain();
    set_policy(1, 1, 300, 200); send_vertex(x); drain();
    set_policy(1, 1, 100, 17'h1_FFFF); send_vertex(x); drain();
  endtask

  // enabled extremes: depth gating, zero throughput, clamps, terminate, overflow
  task automatic test_roulette_cases();
    set_policy(1, 16'hFFFF, 1, 17'h1_0000);
    send_vertex(make_vertex(7, 8, 9, 10, 24'h1_0000, 16'hFFFE, 0));
    send_vertex(make_vertex(1, 0, 0, 0, 24'h1, 16'hFFFF, 0));
    drain();
    set_policy(1, 1, 1, 17'h1_0000);
    send_vertex(make_vertex(0, 0, 0, 0, 24'h1_0000, 1, 0));      // zero throughput
    send_vertex(make_vertex(0, 0, 0, 0, 24'h1_0000, 0, 0));      // below depth
    send_vertex(make_vertex(1, 0, 0, 0, 24'h1, 1, 0));           // clamped to min, survive
    send_vertex(make_vertex(32'hFFFF_FFFF, 1, 2, 3, 24'hFF_FFFF, 5, 16'hFFFF)); // max clamp
    send_vertex(make_vertex(32'h8000, 32'h4000, 1, 0, 24'h1_0000, 2, 16'h7FFF)); // survive
    send_vertex(make_vertex(32'h8000, 32'h4000, 1, 0, 24'h1_0000, 2, 16'h8000)); // terminate
    drain();
    set_policy(1, 3, 17'h0_FFFF, 17'h0_FFFF);
    send_vertex(make_vertex(32'hFFFF_FFFF, 0, 0, 0, 24'h1_0000, 3, 0)); // overflow at p~1
    send_vertex(make_vertex(32'hFFFE_0000, 5, 0, 0, 24'h1_0000, 3, 16'hFFFE));
    drain();
  endtask

  // random vertices under a set of policies
  task automatic test_random_policies(int per_policy);
    logic [15:0]     first;
    rrpt_pkg::prob_t mn, mx;
    for (int k = 0; k < 7; k++) begin
      first = 16'($urandom_range(1, 6));
      mn = rrpt_pkg::prob_t'($urandom_range(1, 17'h0_FFFF));
      mx = rrpt_pkg::prob_t'($urandom_range(mn, 17'h1_0000));
      case (k)
        0: set_policy(0, 0, 0, 0);
        1: set_policy(1, 1, 1, 17'h1_0000);
        2: set_policy(1, 16'hFFFF, 17'h0_FFFF, 17'h1_0000);
        3: set_policy(1, first, 17'h0_8000, 17'h0_8000);
        default: set_policy(1, first, mn, mx);
      endcase
      repeat (per_policy) send_vertex(rand_vertex());
      drain();
    end
  endtask

  // stall the output for a long stretch while the source streams
  task automatic test_backpressure();
    set_policy(1, 2, 17'h0_1000, 17'h0_F000);
    steady_source = 1;
    hold_off = 1;
    repeat (40) send_vertex(rand_vertex());
    steady_source = 0;
    // source pauses until everything is back
    stop_source();
    while (pending_verdicts.size() != 0) @(posedge clk);
    @(negedge clk);
    steady_sink = 1;
    steady_source = 1;
    repeat (60) send_vertex(rand_vertex());
    steady_sink = 0;
    steady_source = 0;
    drain();
  endtask

  initial begin
    mismatches = 0; verdicts_seen = 0;
    survived_seen = 0; terminated_seen = 0; error_seen = 0;
    hold_off = 0; steady_sink = 0; steady_source = 0;
    pol_enabled = 0; pol_first = 0; pol_min = 0; pol_max = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    in_valid = 0;
    in_throughput_lane0 = 0; in_throughput_lane1 = 0;
    in_throughput_lane2 = 0; in_throughput_lane3 = 0;
    in_eta_factor = 0; in_bounce_depth = 0; in_uniform_sample = 0;
    rst_n = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_disabled_passthrough();
    test_bad_policy();
    test_roulette_cases();
    test_random_policies(180);
    test_backpressure();
    drain();
    $display("covered %0d results: %0d survived, %0d terminated, %0d errors",
             verdicts_seen, survived_seen, terminated_seen, error_seen);
    $display("policy settings swept incl. disabled, bad, and extreme bounds");
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
